// File: design/dfc_pkg.sv
`default_nettype none

package dfc_pkg;

    // default widths
    localparam int DUTY_BITS_DEF = 12;
    localparam int TIME_BITS_DEF = 32;

    // configuration field widths
    localparam int WIN_W      = 16;
    localparam int FADE_W     = 16;
    localparam int MAX_DUTY_W = 12;

    // register file addressing
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FADE     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DARK     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DUTY = 2'd3;

    // register reset values
    localparam logic [WIN_W-1:0]      WINDOW_RST   = 16'd1500;
    localparam logic [FADE_W-1:0]     FADE_RST     = 16'd1000;
    localparam logic                  DARK_RST     = 1'b1;
    localparam logic [MAX_DUTY_W-1:0] MAX_DUTY_RST = 12'd4095;

    // lamp modes
    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [1:0] MODE_ON       = 2'd2;
    localparam logic [1:0] MODE_FADE_OUT = 2'd3;

endpackage

`default_nettype wire

// File: design/dfc_div.sv
`default_nettype none

module dfc_div #(
    parameter int DUTY_BITS = dfc_pkg::DUTY_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [DUTY_BITS-1:0]        mul_a,
    input  wire logic [dfc_pkg::FADE_W-1:0]  mul_b,
    input  wire logic [dfc_pkg::FADE_W-1:0]  divisor,
    output logic                             done,
    output logic [DUTY_BITS-1:0]             quotient
);

    localparam int FW     = dfc_pkg::FADE_W;
    localparam int PROD_W = DUTY_BITS + FW;
    localparam int CNT_W  = $clog2(DUTY_BITS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DUTY_BITS-1:0] a_reg, a_next;
    logic [FW-1:0]        b_reg, b_next;
    logic [FW-1:0]        d_reg, d_next;
    logic [FW-1:0]        rem_reg, rem_next;
    logic [DUTY_BITS-1:0] quo_reg, quo_next;

    logic [PROD_W-1:0]    prod;
    logic [FW:0]          shifted;
    logic [FW:0]          trial;

    // product, then one restoring step per quotient bit
    assign prod    = PROD_W'(a_reg) * PROD_W'(b_reg);
    assign shifted = {rem_reg, quo_reg[DUTY_BITS-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    a_next     = mul_a;
                    b_next     = mul_b;
                    d_next     = divisor;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL: begin
                // upper part is below the divisor since the quotient fits the duty width
                rem_next   = prod[PROD_W-1:DUTY_BITS];
                quo_next   = prod[DUTY_BITS-1:0];
                cnt_next   = CNT_W'(DUTY_BITS - 1);
                phase_next = PH_RUN;
            end
            PH_RUN: begin
                if (!trial[FW]) begin
                    rem_next = trial[FW-1:0];
                    quo_next = {quo_reg[DUTY_BITS-2:0], 1'b1};
                end else begin
                    rem_next = shifted[FW-1:0];
                    quo_next = {quo_reg[DUTY_BITS-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // operands and working registers
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: design/debounced_dusk_fade_controller_top.sv
// Dusk lamp controller: debounces a light comparator level and fades a PWM duty.
// Input channel (s_valid/s_ready): one sample per transfer, a millisecond
// timestamp s_now_ms and the raw comparator level s_raw_level.
// Result channel (m_valid/m_ready): one result per sample, the PWM duty,
// the lamp state (off, fading in, on, fading out) and the debounced level.
// Configuration goes through the APB port: window at 0x0, fade time at 0x4,
// dark level at 0x8, full duty at 0xC; write only while the block is idle.
// One sample is worked on at a time. The priming sample goes from the debounce
// step straight to the result, any other sample without a ramp step through the
// debounce and fade steps; during a fade the ramp value goes through a shared
// multiply and restoring divide unit, one quotient bit per cycle. s_ready
// returns together with m_valid, so a new sample is taken only once the last
// one has reached the output register.
// The output register holds a finished result while the receiver stalls; a
// new sample is still taken then, and its result waits until the old one
// leaves. Reset (synchronous, active low) restores the register defaults and
// unprimes the block: the first sample after reset sets the lamp directly.

`default_nettype none

module debounced_dusk_fade_controller_top #(
    parameter int DUTY_BITS = dfc_pkg::DUTY_BITS_DEF,
    parameter int TIME_BITS = dfc_pkg::TIME_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dfc_pkg::DATA_W-1:0]   pwdata,
    output logic [dfc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    // sample channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [TIME_BITS-1:0]         s_now_ms,
    input  wire logic                         s_raw_level,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [DUTY_BITS-1:0]              m_duty,
    output logic [1:0]                        m_lamp_state,
    output logic                              m_stable_level
);

    localparam int WW = dfc_pkg::WIN_W;
    localparam int FW = dfc_pkg::FADE_W;
    localparam int MW = dfc_pkg::MAX_DUTY_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEB  = 3'd1;
    localparam logic [2:0] ST_FADE = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // configuration registers
    logic [WW-1:0]        win_reg;
    logic [FW-1:0]        dur_reg;
    logic                 dark_reg;
    logic [DUTY_BITS-1:0] max_duty_reg;

    logic [dfc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;
    logic [MW-1:0]                 wr_max_duty;

    // sequencer and lamp state
    logic [2:0]           state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 raw_reg, raw_next;
    logic                 primed_reg, primed_next;
    logic [1:0]           mode_reg, mode_next;
    logic [DUTY_BITS-1:0] duty_reg, duty_next;
    logic                 acc_reg, acc_next;
    logic                 prev_reg, prev_next;
    logic [TIME_BITS-1:0] chg_reg, chg_next;
    logic [TIME_BITS-1:0] fst_reg, fst_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [DUTY_BITS-1:0] m_duty_reg, m_duty_next;
    logic [1:0]           m_mode_reg, m_mode_next;
    logic                 m_stable_reg, m_stable_next;

    logic [TIME_BITS-1:0] since_chg;
    logic                 stable_ok;
    logic [TIME_BITS-1:0] elapsed;
    logic                 fade_over;

    logic                 div_start;
    logic                 div_done;
    logic [DUTY_BITS-1:0] div_quo;

    // apb register file
    assign reg_idx     = paddr[dfc_pkg::ADDR_W-1:2];
    assign cfg_write   = psel && penable && pwrite;
    assign wr_max_duty = pwdata[MW-1:0];
    assign pready      = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= dfc_pkg::WINDOW_RST;
            dur_reg      <= dfc_pkg::FADE_RST;
            dark_reg     <= dfc_pkg::DARK_RST;
            max_duty_reg <= DUTY_BITS'(dfc_pkg::MAX_DUTY_RST);
        end else if (cfg_write) begin
            case (reg_idx)
                dfc_pkg::REG_WINDOW:   win_reg      <= pwdata[WW-1:0];
                dfc_pkg::REG_FADE:     dur_reg      <= pwdata[FW-1:0];
                dfc_pkg::REG_DARK:     dark_reg     <= pwdata[0];
                dfc_pkg::REG_MAX_DUTY: max_duty_reg <= DUTY_BITS'(wr_max_duty);
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            dfc_pkg::REG_WINDOW:   prdata = dfc_pkg::DATA_W'(win_reg);
            dfc_pkg::REG_FADE:     prdata = dfc_pkg::DATA_W'(dur_reg);
            dfc_pkg::REG_DARK:     prdata = dfc_pkg::DATA_W'(dark_reg);
            dfc_pkg::REG_MAX_DUTY: prdata = dfc_pkg::DATA_W'(max_duty_reg);
            default:               prdata = '0;
        endcase
    end

    // debounce check: a fresh raw change has zero hold time
    assign since_chg = now_reg - chg_reg;
    assign stable_ok = (raw_reg != prev_reg) ? (win_reg == '0)
                                             : (since_chg >= TIME_BITS'(win_reg));

    // fade progress
    assign elapsed   = now_reg - fst_reg;
    assign fade_over = elapsed >= TIME_BITS'(dur_reg);

    // shared multiply and divide unit for the ramp
    dfc_div #(
        .DUTY_BITS (DUTY_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mul_a    (max_duty_reg),
        .mul_b    (elapsed[FW-1:0]),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        raw_next      = raw_reg;
        primed_next   = primed_reg;
        mode_next     = mode_reg;
        duty_next     = duty_reg;
        acc_next      = acc_reg;
        prev_next     = prev_reg;
        chg_next      = chg_reg;
        fst_next      = fst_reg;
        m_valid_next  = m_valid_reg;
        m_duty_next   = m_duty_reg;
        m_mode_next   = m_mode_reg;
        m_stable_next = m_stable_reg;
        div_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next   = s_now_ms;
                    raw_next   = s_raw_level;
                    state_next = ST_DEB;
                end
            end
            ST_DEB: begin
                if (!primed_reg) begin
                    primed_next = 1'b1;
                    acc_next    = raw_reg;
                    prev_next   = raw_reg;
                    chg_next    = now_reg;
                    if (raw_reg == dark_reg) begin
                        mode_next = dfc_pkg::MODE_ON;
                        duty_next = max_duty_reg;
                    end else begin
                        mode_next = dfc_pkg::MODE_OFF;
                        duty_next = '0;
                    end
                    state_next = ST_DONE;
                end else begin
                    if (raw_reg != prev_reg) begin
                        prev_next = raw_reg;
                        chg_next  = now_reg;
                    end
                    if (stable_ok && (raw_reg != acc_reg)) begin
                        acc_next  = raw_reg;
                        mode_next = (raw_reg == dark_reg) ? dfc_pkg::MODE_FADE_IN
                                                          : dfc_pkg::MODE_FADE_OUT;
                        fst_next  = now_reg;
                    end
                    state_next = ST_FADE;
                end
            end
            ST_FADE: begin
                case (mode_reg)
                    dfc_pkg::MODE_FADE_IN: begin
                        if (fade_over) begin
                            duty_next  = max_duty_reg;
                            mode_next  = dfc_pkg::MODE_ON;
                            state_next = ST_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    dfc_pkg::MODE_FADE_OUT: begin
                        if (fade_over) begin
                            duty_next  = '0;
                            mode_next  = dfc_pkg::MODE_OFF;
                            state_next = ST_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    dfc_pkg::MODE_ON: begin
                        duty_next  = max_duty_reg;
                        state_next = ST_DONE;
                    end
                    default: begin
                        duty_next  = '0;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    duty_next  = (mode_reg == dfc_pkg::MODE_FADE_IN) ? div_quo
                                                                     : max_duty_reg - div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_duty_next   = duty_reg;
                    m_mode_next   = mode_reg;
                    m_stable_next = acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and lamp state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            primed_reg  <= 1'b0;
            mode_reg    <= dfc_pkg::MODE_OFF;
            duty_reg    <= '0;
            acc_reg     <= 1'b0;
            prev_reg    <= 1'b0;
            chg_reg     <= '0;
            fst_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            primed_reg  <= primed_next;
            mode_reg    <= mode_next;
            duty_reg    <= duty_next;
            acc_reg     <= acc_next;
            prev_reg    <= prev_next;
            chg_reg     <= chg_next;
            fst_reg     <= fst_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // sample and result payload
    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        raw_reg      <= raw_next;
        m_duty_reg   <= m_duty_next;
        m_mode_reg   <= m_mode_next;
        m_stable_reg <= m_stable_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_duty         = m_duty_reg;
    assign m_lamp_state   = m_mode_reg;
    assign m_stable_level = m_stable_reg;

`ifndef SYNTH
    // an accepted sample always goes to the debounce step next
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_DEB)
        else $error("sample transfer did not start the debounce step");

    // the ramp unit only reports back while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("ramp result arrived outside the divide wait");

    // a lamp that is on shows full duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lamp_state == dfc_pkg::MODE_ON |-> m_duty == max_duty_reg)
        else $error("lamp on without full duty");

    // a lamp that is off shows zero duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lamp_state == dfc_pkg::MODE_OFF |-> m_duty == '0)
        else $error("lamp off with nonzero duty");

    // duty never goes past full brightness
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty <= max_duty_reg)
        else $error("duty above full brightness");
`endif

endmodule

`default_nettype wire

// File: bench/debounced_dusk_fade_controller_top_tb.sv
`default_nettype none

module debounced_dusk_fade_controller_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_W = dfc_pkg::DUTY_BITS_DEF;
    localparam int TIME_W = dfc_pkg::TIME_BITS_DEF;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [1:0]        lamp;
        logic              stable;
    } lamp_result_t;

    // clock, reset and block ports
    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [dfc_pkg::ADDR_W-1:0]     paddr = '0;
    logic [dfc_pkg::DATA_W-1:0]     pwdata = '0;
    logic [dfc_pkg::DATA_W-1:0]     prdata;
    logic                           pready;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [TIME_W-1:0]              s_now_ms = '0;
    logic                           s_raw_level = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [DUTY_W-1:0]              m_duty;
    logic [1:0]                     m_lamp_state;
    logic                           m_stable_level;

    // shadow copy of the configuration registers
    logic [dfc_pkg::WIN_W-1:0]      cfg_window = dfc_pkg::WINDOW_RST;
    logic [dfc_pkg::FADE_W-1:0]     cfg_fade = dfc_pkg::FADE_RST;
    logic                           cfg_dark = dfc_pkg::DARK_RST;
    logic [dfc_pkg::MAX_DUTY_W-1:0] cfg_max = dfc_pkg::MAX_DUTY_RST;

    // lamp model state
    logic                           lm_primed = 1'b0;
    logic [1:0]                     lm_mode = dfc_pkg::MODE_OFF;
    logic [DUTY_W-1:0]              lm_duty = '0;
    logic                           lm_accepted = 1'b0;
    logic                           lm_prev_raw = 1'b0;
    logic [TIME_W-1:0]              lm_change_t = '0;
    logic [TIME_W-1:0]              lm_fade_t = '0;

    lamp_result_t                   pending_lamp_q[$];
    logic [TIME_W-1:0]              t_ms = '0;
    logic                           quiet = 1'b0;
    int                             rx_hold = 0;
    int                             n_err = 0;
    int                             n_samples = 0;
    int                             n_results = 0;
    int                             n_settings = 0;
    int                             state_seen[4] = '{0, 0, 0, 0};

    debounced_dusk_fade_controller_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_now_ms      (s_now_ms),
        .s_raw_level   (s_raw_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_lamp_state  (m_lamp_state),
        .m_stable_level(m_stable_level)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("debounced_dusk_fade_controller_top_tb: done, errors");
        $finish;
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [dfc_pkg::DATA_W-1:0] reg_mask(
        input logic [dfc_pkg::REG_IDX_W-1:0] idx);
        case (idx)
            dfc_pkg::REG_WINDOW: return (1 << dfc_pkg::WIN_W) - 1;
            dfc_pkg::REG_FADE:   return (1 << dfc_pkg::FADE_W) - 1;
            dfc_pkg::REG_DARK:   return 1;
            default:             return (1 << dfc_pkg::MAX_DUTY_W) - 1;
        endcase
    endfunction

    // debounce and fade prediction for one accepted sample
    task automatic predict_lamp(input logic [TIME_W-1:0] now, input logic raw);
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       prod_a;
        logic [63:0]       prod_b;
        logic [63:0]       ramp;
        lamp_result_t      r;
        if (!lm_primed) begin
            lm_primed   = 1'b1;
            lm_accepted = raw;
            lm_prev_raw = raw;
            lm_change_t = now;
            if (raw == cfg_dark) begin
                lm_mode = dfc_pkg::MODE_ON;
                lm_duty = cfg_max;
            end else begin
                lm_mode = dfc_pkg::MODE_OFF;
                lm_duty = '0;
            end
        end else begin
            if (raw != lm_prev_raw) begin
                lm_prev_raw = raw;
                lm_change_t = now;
            end
            held = now - lm_change_t;
            if (held >= cfg_window && raw != lm_accepted) begin
                lm_accepted = raw;
                lm_mode     = (raw == cfg_dark) ? dfc_pkg::MODE_FADE_IN
                                                : dfc_pkg::MODE_FADE_OUT;
                lm_fade_t   = now;
            end
            elapsed = now - lm_fade_t;
            prod_a  = 64'(cfg_max);
            prod_b  = 64'(elapsed);
            ramp    = '0;
            if (elapsed < cfg_fade) ramp = (prod_a * prod_b) / cfg_fade;
            case (lm_mode)
                dfc_pkg::MODE_FADE_IN: begin
                    if (elapsed >= cfg_fade) begin
                        lm_duty = cfg_max;
                        lm_mode = dfc_pkg::MODE_ON;
                    end else begin
                        lm_duty = ramp[DUTY_W-1:0];
                    end
                end
                dfc_pkg::MODE_FADE_OUT: begin
                    if (elapsed >= cfg_fade) begin
                        lm_duty = '0;
                        lm_mode = dfc_pkg::MODE_OFF;
                    end else begin
                        lm_duty = cfg_max - ramp[DUTY_W-1:0];
                    end
                end
                dfc_pkg::MODE_ON: lm_duty = cfg_max;
                default:          lm_duty = '0;
            endcase
        end
        r.duty   = lm_duty;
        r.lamp   = lm_mode;
        r.stable = lm_accepted;
        pending_lamp_q.push_back(r);
    endtask

    // result receiver with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            rx_hold <= pick_gap();
        end
    end

    // result check first, then prediction for a sample taken at the same edge
    always @(posedge aclk) begin : lamp_monitor
        lamp_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (pending_lamp_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: duty %0d state %0d stable %0d",
                                 m_duty, m_lamp_state, m_stable_level);
                end else begin
                    want = pending_lamp_q.pop_front();
                    state_seen[want.lamp]++;
                    if (m_duty !== want.duty || m_lamp_state !== want.lamp ||
                        m_stable_level !== want.stable) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("result %0d mismatch: expected duty %0d state %0d %s",
                                     n_results, want.duty, want.lamp,
                                     $sformatf("stable %0d, got duty %0d state %0d stable %0d",
                                               want.stable, m_duty, m_lamp_state,
                                               m_stable_level));
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_samples++;
                predict_lamp(s_now_ms, s_raw_level);
            end
        end
    end

    // register write: setup cycle and access cycle, then the bus goes idle
    task automatic cfg_write(input logic [dfc_pkg::REG_IDX_W-1:0] idx,
                             input logic [dfc_pkg::DATA_W-1:0] value);
        logic [dfc_pkg::DATA_W-1:0] mask;
        mask    = reg_mask(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            dfc_pkg::REG_WINDOW: cfg_window = value[dfc_pkg::WIN_W-1:0];
            dfc_pkg::REG_FADE:   cfg_fade   = value[dfc_pkg::FADE_W-1:0];
            dfc_pkg::REG_DARK:   cfg_dark   = value[0];
            default:             cfg_max    = value[dfc_pkg::MAX_DUTY_W-1:0];
        endcase
        @(posedge aclk);
    endtask

    // register read compared with the shadow copy
    task automatic cfg_read_check(input logic [dfc_pkg::REG_IDX_W-1:0] idx);
        logic [dfc_pkg::DATA_W-1:0] want;
        case (idx)
            dfc_pkg::REG_WINDOW: want = dfc_pkg::DATA_W'(cfg_window);
            dfc_pkg::REG_FADE:   want = dfc_pkg::DATA_W'(cfg_fade);
            dfc_pkg::REG_DARK:   want = dfc_pkg::DATA_W'(cfg_dark);
            default:             want = dfc_pkg::DATA_W'(cfg_max);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if ((prdata & reg_mask(idx)) !== want) begin
            n_err++;
            if (n_err <= 10)
                $display("register %0d read: expected %0d, got %0d", idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int win, input int fade, input int dark, input int maxd);
        cfg_write(dfc_pkg::REG_WINDOW, win);
        cfg_write(dfc_pkg::REG_FADE, fade);
        cfg_write(dfc_pkg::REG_DARK, dark);
        cfg_write(dfc_pkg::REG_MAX_DUTY, maxd);
        cfg_read_check(dfc_pkg::REG_WINDOW);
        cfg_read_check(dfc_pkg::REG_FADE);
        cfg_read_check(dfc_pkg::REG_DARK);
        cfg_read_check(dfc_pkg::REG_MAX_DUTY);
        n_settings++;
    endtask

    // one sample transfer; valid stays high when no gap follows
    task automatic send_sample(input logic [TIME_W-1:0] now, input logic raw);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_now_ms    <= now;
        s_raw_level <= raw;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_after(input int dt, input logic raw);
        t_ms = t_ms + dt;
        send_sample(t_ms, raw);
    endtask

    // let every outstanding result drain before touching registers;
    // first wait for a clock edge so the last transfer is already predicted
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lamp_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // level runs with occasional glitches and timestamp jumps
    task automatic drive_level_runs(input int count, input int step_hi,
                                    input int glitch_pct, input int jump_pct);
        int   hold;
        logic level;
        logic raw;
        hold  = 0;
        level = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++) begin
            if (hold == 0) begin
                level = ~level;
                hold  = $urandom_range(1, 30);
            end
            hold--;
            raw = level;
            if ($urandom_range(0, 99) < glitch_pct) raw = ~level;
            if ($urandom_range(0, 99) < jump_pct) t_ms = $urandom;
            else t_ms = t_ms + $urandom_range(0, step_hi);
            send_sample(t_ms, raw);
        end
    endtask

    // random register setting, extremes included
    task automatic pick_setting(output int step_hi);
        int r;
        int win;
        int fade;
        int maxd;
        r = $urandom_range(0, 99);
        win = (r < 15) ? 0 : (r < 25) ? 65535 : $urandom_range(1, 2000);
        r = $urandom_range(0, 99);
        fade = (r < 10) ? 1 : (r < 20) ? 65535 : $urandom_range(1, 3000);
        r = $urandom_range(0, 99);
        maxd = (r < 10) ? 1 : (r < 20) ? 4095 : $urandom_range(1, 4095);
        apply_setting(win, fade, $urandom_range(0, 1), maxd);
        step_hi = (win + fade) / 6 + 1;
    endtask

    // reset values and the priming sample
    task automatic test_reset_and_priming();
        cfg_read_check(dfc_pkg::REG_WINDOW);
        cfg_read_check(dfc_pkg::REG_FADE);
        cfg_read_check(dfc_pkg::REG_DARK);
        cfg_read_check(dfc_pkg::REG_MAX_DUTY);
        t_ms = '0;
        send_sample(t_ms, 1'b1);
        wait_idle();
    endtask

    // full fade out then fade in
    task automatic test_fade_cycle();
        apply_setting(10, 100, 1, 4095);
        send_after(5, 1'b0);
        send_after(10, 1'b0);
        send_after(50, 1'b0);
        send_after(50, 1'b0);
        send_after(1, 1'b1);
        send_after(10, 1'b1);
        send_after(99, 1'b1);
        send_after(1, 1'b1);
        wait_idle();
    endtask

    // zero window: new level taken at once, fades restarted midway
    task automatic test_restart_zero_window();
        apply_setting(0, 100, 1, 4095);
        send_after(1, 1'b0);
        send_after(30, 1'b1);
        send_after(30, 1'b0);
        send_after(200, 1'b0);
        wait_idle();
    endtask

    // zero fade time, then zero full duty
    task automatic test_zero_fade_and_duty();
        apply_setting(0, 0, 1, 4095);
        send_after(1, 1'b1);
        send_after(1, 1'b0);
        wait_idle();
        apply_setting(0, 50, 1, 0);
        send_after(1, 1'b1);
        send_after(1, 1'b0);
        wait_idle();
    endtask

    // timestamp wrap and a timestamp going backwards
    task automatic test_wrap_and_backwards();
        apply_setting(100, 1000, 1, 4095);
        send_sample(32'hFFFF_FFC0, 1'b1);
        send_sample(32'h0000_0030, 1'b1);
        send_sample(32'h0000_0010, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        wait_idle();
    endtask

    // largest window and fade with a full duty of 1
    task automatic test_register_extremes();
        apply_setting(65535, 65535, 0, 1);
        send_sample(32'h0000_FFFE, 1'b0);
        send_sample(32'h0001_7FFE, 1'b0);
        t_ms = 32'h0001_FFFD;
        send_sample(t_ms, 1'b0);
        wait_idle();
    endtask

    // well-formed level runs under many settings
    task automatic test_random_runs();
        int step_hi;
        for (int p = 0; p < 10; p++) begin
            pick_setting(step_hi);
            quiet = (p % 4 == 1);
            drive_level_runs(140, step_hi, 3, 1);
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    // chattering levels and scattered timestamps
    task automatic test_random_noise();
        int step_hi;
        for (int p = 0; p < 2; p++) begin
            pick_setting(step_hi);
            drive_level_runs(100, step_hi, 50, 30);
            wait_idle();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_and_priming();
        test_fade_cycle();
        test_restart_zero_window();
        test_zero_fade_and_duty();
        test_wrap_and_backwards();
        test_register_extremes();
        test_random_runs();
        test_random_noise();

        // final drain plus a margin for a stray result
        wait_idle();
        repeat (40) @(posedge aclk);

        $display("%0d samples, %0d results checked under %0d register settings",
                 n_samples, n_results, n_settings);
        $display("results by lamp state: off %0d, fading in %0d, on %0d, fading out %0d",
                 state_seen[dfc_pkg::MODE_OFF], state_seen[dfc_pkg::MODE_FADE_IN],
                 state_seen[dfc_pkg::MODE_ON], state_seen[dfc_pkg::MODE_FADE_OUT]);
        if (n_err == 0 && pending_lamp_q.size() == 0) begin
            $display("debounced_dusk_fade_controller_top_tb: done, clean");
        end else begin
            $display("%0d errors, %0d results never arrived", n_err, pending_lamp_q.size());
            $display("debounced_dusk_fade_controller_top_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
